// ===== hdl/first_fit_region_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// first-fit region allocator assertion macros
// shared property forms for the allocator checks, clocked on clock and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define FFRA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// widths, codes and shared types of the first-fit region allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

   localparam int MAX_REGIONS_DEF = 64;

   localparam int ADDR_W     = 64;
   localparam int START_W    = 64;
   localparam int PAGES_W    = 36;
   localparam int BYTES_W    = 32;
   localparam int TYPE_W     = 4;
   localparam int UNITS_W    = 48;
   localparam int STATUS_W   = 3;
   localparam int UNIT_SHIFT = 4;   // 16-byte units
   localparam int PAGE_SHIFT = 8;   // 256 units per 4 KiB page
   localparam int NEED_W     = BYTES_W - UNIT_SHIFT + 1;

   localparam logic [ADDR_W-1:0] UNIT_BYTES = ADDR_W'(16);

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [TYPE_W-1:0] MT_BOOT_CODE    = TYPE_W'(3);
   localparam logic [TYPE_W-1:0] MT_BOOT_DATA    = TYPE_W'(4);
   localparam logic [TYPE_W-1:0] MT_CONVENTIONAL = TYPE_W'(7);

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED     = 3'd0,
      STAT_IGNORED   = 3'd1,
      STAT_ALLOCATED = 3'd2,
      STAT_NOMEM     = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_HIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [UNITS_W-1:0]   units;
      logic [START_W-1:0]   start;
   } entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      status_type        status;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type res;
   } rsp_push_type;

   function automatic logic usable_type(input logic [TYPE_W-1:0] t);
      return (t == MT_BOOT_CODE) || (t == MT_BOOT_DATA) || (t == MT_CONVENTIONAL);
   endfunction

endpackage

// ===== hdl/ffra_req_if.sv =====
// ----------------------------------------------------------------------------
// ffra_req_if
// request channel: descriptor adds and allocate requests
// ----------------------------------------------------------------------------
interface ffra_req_if import ffra_pkg::*; ();

   logic               valid;
   logic               ready;
   logic               command;
   logic [TYPE_W-1:0]  mem_type;
   logic [START_W-1:0] region_start;
   logic [PAGES_W-1:0] page_count;
   logic [BYTES_W-1:0] request_bytes;

   modport source (
      output valid, command, mem_type, region_start, page_count, request_bytes,
      input  ready
   );

   modport sink (
      input  valid, command, mem_type, region_start, page_count, request_bytes,
      output ready
   );

endinterface

// ===== hdl/ffra_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffra_rsp_if
// response channel: allocated address and status
// ----------------------------------------------------------------------------
interface ffra_rsp_if import ffra_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   address;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, address, status,
      input  ready
   );

   modport sink (
      input  valid, address, status,
      output ready
   );

endinterface

// ===== hdl/ffra_ram.sv =====
// ----------------------------------------------------------------------------
// ffra_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/ffra_out_reg.sv =====
// ----------------------------------------------------------------------------
// ffra_out_reg
// response holding register, decouples the engine from the response channel
// ----------------------------------------------------------------------------
module ffra_out_reg import ffra_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         space,
   ffra_rsp_if.source   rsp_chan
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push.push) begin
         valid_in = 1'b1;
         data_in  = push.res;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.address = data_ff.address;
   assign rsp_chan.status  = data_ff.status;

endmodule

// ===== hdl/ffra_engine.sv =====
// ----------------------------------------------------------------------------
// ffra_engine
// request sequencer: appends regions, scans the region table newest first,
// shrinks or retires the chosen region
// ----------------------------------------------------------------------------
module ffra_engine import ffra_pkg::*; #(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF,
   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
   localparam int CW = $clog2(MAX_REGIONS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   ffra_req_if.sink                 req_chan,
   output logic                     ram_we,
   output logic [AW-1:0]            ram_waddr,
   output logic [$bits(entry_type)-1:0] ram_wdata,
   output logic [AW-1:0]            ram_raddr,
   input  logic [$bits(entry_type)-1:0] ram_rdata,
   output rsp_push_type             push,
   input  logic                     space
);

   localparam int OFF_PAD = ADDR_W - UNITS_W - UNIT_SHIFT;

   state_type           state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       idx_ff, idx_in;

   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [UNITS_W-1:0]  units_ff, units_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [NEED_W-1:0]   needm1_ff, needm1_in;

   logic                hit_exact_ff, hit_exact_in;
   logic [START_W-1:0]  hit_start_ff, hit_start_in;
   logic [UNITS_W-1:0]  hit_units_ff, hit_units_in;
   logic [UNITS_W-1:0]  hit_off_ff, hit_off_in;
   result_type          res_ff, res_in;

   logic [CW-1:0]       fill_m1;
   logic [NEED_W-1:0]   ceil_units;
   logic                full;
   entry_type           rd;
   entry_type           wr;
   logic [UNITS_W-1:0]  need_ext;
   logic [UNITS_W-1:0]  needm1_ext;
   logic                fits;

   assign fill_m1    = fill_ff - CW'(1);
   assign full       = (fill_ff == CW'(MAX_REGIONS));
   assign ceil_units = NEED_W'(req_chan.request_bytes[BYTES_W-1:UNIT_SHIFT])
                     + NEED_W'(|req_chan.request_bytes[UNIT_SHIFT-1:0]);
   assign rd         = entry_type'(ram_rdata);
   assign need_ext   = UNITS_W'(need_ff);
   assign needm1_ext = UNITS_W'(needm1_ff);
   assign fits       = rd.valid && (rd.units >= need_ext);
   assign ram_wdata  = wr;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      type_in      = type_ff;
      start_in     = start_ff;
      units_in     = units_ff;
      need_in      = need_ff;
      needm1_in    = needm1_ff;
      hit_exact_in = hit_exact_ff;
      hit_start_in = hit_start_ff;
      hit_units_in = hit_units_ff;
      hit_off_in   = hit_off_ff;
      res_in       = res_ff;
      req_chan.ready = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = fill_ff[AW-1:0];
      ram_raddr    = idx_ff;
      wr           = '{valid: 1'b1, units: units_ff, start: start_ff};
      push         = '{push: 1'b0, res: res_ff};

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            ram_raddr      = fill_m1[AW-1:0];
            if (req_chan.valid) begin
               type_in   = req_chan.mem_type;
               start_in  = req_chan.region_start;
               units_in  = UNITS_W'({req_chan.page_count, {PAGE_SHIFT{1'b0}}});
               needm1_in = ceil_units;
               need_in   = ceil_units + NEED_W'(1);
               if (req_chan.command == CMD_ADD) begin
                  state_in = S_ADD;
               end else if (fill_ff == '0) begin
                  res_in   = '{address: '0, status: STAT_NOMEM};
                  state_in = S_RESP;
               end else begin
                  idx_in   = fill_m1[AW-1:0];
                  state_in = S_SCAN;
               end
            end
         end
         S_ADD: begin
            if (!usable_type(type_ff)) begin
               res_in = '{address: '0, status: STAT_IGNORED};
            end else if (full) begin
               res_in = '{address: '0, status: STAT_FULL};
            end else begin
               ram_we  = 1'b1;
               fill_in = fill_ff + CW'(1);
               res_in  = '{address: '0, status: STAT_ADDED};
            end
            state_in = S_RESP;
         end
         S_SCAN: begin
            // read of the next older entry goes out while this one is checked
            ram_raddr = idx_ff - AW'(1);
            if (fits) begin
               hit_exact_in = (rd.units == need_ext);
               hit_start_in = rd.start;
               hit_units_in = rd.units - need_ext;
               hit_off_in   = rd.units - needm1_ext;
               state_in     = S_HIT;
            end else if (idx_ff == '0) begin
               res_in   = '{address: '0, status: STAT_NOMEM};
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         S_HIT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            wr        = '{valid: !hit_exact_ff, units: hit_units_ff, start: hit_start_ff};
            // block sits at the region end, payload one unit past its header
            if (hit_exact_ff) begin
               res_in.address = hit_start_ff + UNIT_BYTES;
            end else begin
               res_in.address = hit_start_ff
                              + {{OFF_PAD{1'b0}}, hit_off_ff, {UNIT_SHIFT{1'b0}}};
            end
            res_in.status = STAT_ALLOCATED;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (space) begin
               push.push = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      idx_ff       <= idx_in;
      type_ff      <= type_in;
      start_ff     <= start_in;
      units_ff     <= units_in;
      need_ff      <= need_in;
      needm1_ff    <= needm1_in;
      hit_exact_ff <= hit_exact_in;
      hit_start_ff <= hit_start_in;
      hit_units_ff <= hit_units_in;
      hit_off_ff   <= hit_off_in;
      res_ff       <= res_in;
   end

endmodule

// ===== hdl/first_fit_region_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top
// first-fit allocator over a table of free memory regions
// ----------------------------------------------------------------------------
// One request at a time. A descriptor add (command 0) goes from acceptance
// through the add and response states to the output register: usable types
// 3, 4 and 7 are appended to the region table as start and 16-byte unit
// count, others are ignored, and once MAX_REGIONS entries have been appended
// further usable adds report table full. An allocate (command 1) reads the
// region table, one entry per cycle through the single read port of the
// table ram, from the newest entry to the oldest, and takes the first live
// region that fits, by way of the scan, hit and response states; when none
// fits it goes from the scan state to the response state, and on an empty
// table straight to the response state. The response register holds one
// finished response while the next request is accepted; a stalled response
// holds the engine once a second one is ready. The table needs no clearing
// after reset: only entries below the fill count are ever checked.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_top import ffra_pkg::*; #(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ffra_req_if.sink   req_chan,
   ffra_rsp_if.source rsp_chan
);

   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int EW = $bits(entry_type);

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;
   rsp_push_type  push;
   logic          space;

   ffra_engine #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .push      (push),
      .space     (space)
   );

   ffra_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ffra_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== hdl/ffra_checker.sv =====
// ----------------------------------------------------------------------------
// ffra_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "first_fit_region_allocator_top_assert.svh"

module ffra_checker import ffra_pkg::*; #(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF,
   localparam int CW = $clog2(MAX_REGIONS + 1)
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ADDR_W-1:0]   rsp_address,
   input logic [STATUS_W-1:0] rsp_status
);

   logic [1:0]    pend_ff, pend_in;
   logic [CW-1:0] added_ff, added_in;
   logic          req_acc;
   logic          rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in  = pend_ff + 2'(req_acc) - 2'(rsp_acc);
      added_in = added_ff;
      if (rsp_acc && (rsp_status == STAT_ADDED) && (added_ff != CW'(MAX_REGIONS))) begin
         added_in = added_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         added_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         added_ff <= added_in;
      end
   end

   `FFRA_ASSERT_IMPL(a_addr_zero, rsp_valid && (rsp_status != STAT_ALLOCATED), rsp_address == '0, "nonzero address on a response that is not an allocation")
   `FFRA_ASSERT_IMPL(a_no_orphan, rsp_valid, pend_ff != 2'd0, "response without an outstanding request")
   `FFRA_ASSERT_IMPL(a_full_count, rsp_valid && (rsp_status == STAT_FULL), added_ff == CW'(MAX_REGIONS), "table full reported before the table was filled")
   `FFRA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_address) && $stable(rsp_status), "stalled response changed")

endmodule

bind first_fit_region_allocator_top ffra_checker #(
   .MAX_REGIONS (MAX_REGIONS)
) u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_address (rsp_chan.address),
   .rsp_status  (rsp_chan.status)
);

// ===== sim/first_fit_region_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_checker
// watches both channels of the region allocator, keeps its own copy of the
// free-region table, predicts every response and compares it in order
// ----------------------------------------------------------------------------
module first_fit_region_allocator_checker import ffra_pkg::*; #(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
   input  logic clock,
   input  logic reset,
   ffra_req_if  req_mon,
   ffra_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [START_W-1:0] table_start [MAX_REGIONS];
   logic [UNITS_W-1:0] table_units [MAX_REGIONS];
   bit                 table_live  [MAX_REGIONS];
   int                 table_fill;
   result_type         due_q [$];

   function automatic bit is_usable(input logic [TYPE_W-1:0] mtype);
      return (mtype == MT_BOOT_CODE) || (mtype == MT_BOOT_DATA) ||
             (mtype == MT_CONVENTIONAL);
   endfunction

   // applies one request to the table copy and returns the response it earns
   function automatic result_type step_region_table(
      input logic               cmd,
      input logic [TYPE_W-1:0]  mtype,
      input logic [START_W-1:0] start,
      input logic [PAGES_W-1:0] pages,
      input logic [BYTES_W-1:0] bytes
   );
      result_type         res;
      logic [UNITS_W-1:0] need;
      res.address = '0;
      if (cmd == CMD_ADD) begin
         if (!is_usable(mtype)) begin
            res.status = STAT_IGNORED;
         end else if (table_fill >= MAX_REGIONS) begin
            res.status = STAT_FULL;
         end else begin
            table_start[table_fill] = start;
            table_units[table_fill] = UNITS_W'(pages) << PAGE_SHIFT;
            table_live[table_fill]  = 1'b1;
            table_fill++;
            res.status = STAT_ADDED;
         end
      end else begin
         // round up to units, plus the header unit
         need = ((UNITS_W'(bytes) + UNITS_W'(UNIT_BYTES - 1)) >> UNIT_SHIFT) + 1;
         res.status = STAT_NOMEM;
         for (int i = table_fill - 1; i >= 0; i--) begin
            if (table_live[i] && table_units[i] >= need) begin
               if (table_units[i] == need) begin
                  table_live[i] = 1'b0;
                  res.address = table_start[i] + UNIT_BYTES;
               end else begin
                  // carve from the region's end
                  table_units[i] = table_units[i] - need;
                  res.address = table_start[i] + (ADDR_W'(table_units[i]) << UNIT_SHIFT)
                                + UNIT_BYTES;
               end
               res.status = STAT_ALLOCATED;
               break;
            end
         end
      end
      return res;
   endfunction

   task automatic log_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: response mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         table_fill = 0;
         foreach (table_live[i]) table_live[i] = 1'b0;
         due_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_q.size() == 0) begin
               log_failure($sformatf("nothing due, got address %h status %0d",
                                     rsp_mon.address, rsp_mon.status));
            end else begin
               want = due_q.pop_front();
               if (rsp_mon.address !== want.address || rsp_mon.status !== want.status)
                  log_failure($sformatf("expected address %h status %0d, got address %h status %0d",
                                        want.address, want.status,
                                        rsp_mon.address, rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready)
            due_q.push_back(step_region_table(req_mon.command, req_mon.mem_type,
                                              req_mon.region_start, req_mon.page_count,
                                              req_mon.request_bytes));
      end
      results_due = due_q.size();
   end

endmodule

// ===== sim/first_fit_region_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top_tb
// drives descriptor adds and allocate requests into the region allocator:
// a directed opening, then random traffic under three idling patterns;
// checking is done by the checker instance beside the block
// ----------------------------------------------------------------------------
module first_fit_region_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffra_pkg::*;

   localparam int REGIONS          = MAX_REGIONS_DEF;
   localparam int RANDOM_PER_PHASE = 377;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int DRAIN_CYCLES     = 80;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned gap_pct   = 12;
   int unsigned stall_pct = 50;
   int          idle_cycles = 0;
   int          usable_sent = 0;
   int          failures;
   int          results_due;

   ffra_req_if req_chan ();
   ffra_rsp_if rsp_chan ();

   first_fit_region_allocator_top #(
      .MAX_REGIONS(REGIONS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   first_fit_region_allocator_checker #(
      .MAX_REGIONS(REGIONS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (failures),
      .results_due    (results_due)
   );

   always begin
      #4ns clock = 1'b1;
      #4ns clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // no request or response moving for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(
      input logic               cmd,
      input logic [TYPE_W-1:0]  mtype,
      input logic [START_W-1:0] start,
      input logic [PAGES_W-1:0] pages,
      input logic [BYTES_W-1:0] bytes
   );
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.command       <= cmd;
      req_chan.mem_type      <= mtype;
      req_chan.region_start  <= start;
      req_chan.page_count    <= pages;
      req_chan.request_bytes <= bytes;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // mostly small regions so that exact fits and out of memory both happen;
   // huge regions only late, since they would absorb every request
   function automatic logic [PAGES_W-1:0] pick_pages();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)
         return '0;
      if (r < 50)
         return PAGES_W'($urandom_range(4, 1));
      if (r < 80)
         return PAGES_W'($urandom_range(255, 5));
      if (r < 95 || usable_sent < 40)
         return PAGES_W'($urandom_range(65535, 256));
      return PAGES_W'({$urandom, $urandom});
   endfunction

   function automatic logic [BYTES_W-1:0] pick_bytes();
      int unsigned r;
      int unsigned k;
      r = $urandom_range(99);
      k = $urandom_range(4, 1);
      if (r < 40)
         return BYTES_W'((((k << PAGE_SHIFT) - 1) << UNIT_SHIFT) - $urandom_range(15));
      if (r < 80)
         return BYTES_W'($urandom_range(4096, 0));
      if (r < 95)
         return BYTES_W'($urandom_range(65535, 0));
      return BYTES_W'($urandom);
   endfunction

   task automatic run_directed();
      send_request(CMD_ALLOC, '0, '0, '0, '0);                       // empty table
      send_request(CMD_ADD, TYPE_W'(0), '1, '1, '1);                 // unusable type
      send_request(CMD_ADD, '1, '0, '0, '0);
      send_request(CMD_ADD, MT_BOOT_CODE, '0, '0, '0);               // zero-page region
      send_request(CMD_ALLOC, '0, '0, '0, '0);                       // it never fits
      send_request(CMD_ADD, MT_BOOT_DATA, 64'hFFFF_FFFF_FFFF_F000, PAGES_W'(1), '0);
      send_request(CMD_ALLOC, '0, '0, '0, '0);                       // address wraps to zero
      send_request(CMD_ALLOC, '0, '0, '0, BYTES_W'(4064));           // exact fit of the rest
      send_request(CMD_ALLOC, '0, '0, '0, BYTES_W'(1));
      send_request(CMD_ADD, MT_CONVENTIONAL, 64'h0000_0000_0010_0000, PAGES_W'(2), '0);
      send_request(CMD_ADD, MT_BOOT_CODE, 64'h0000_0000_2000_0007, PAGES_W'(1), '0);
      send_request(CMD_ALLOC, '0, '0, '0, BYTES_W'(17));             // unaligned start
      send_request(CMD_ALLOC, '0, '0, '0, BYTES_W'(4800));           // skips the newest
      send_request(CMD_ALLOC, '0, '0, '0, '1);
      send_request(CMD_ALLOC, '0, '0, '0, BYTES_W'(16));
      send_request(CMD_ADD, TYPE_W'(2), '1, '1, '1);
      send_request(CMD_ALLOC, '1, '1, '1, '0);                       // unused fields set
   endtask

   task automatic run_random(input int count);
      int                 n;
      int unsigned        r;
      logic [TYPE_W-1:0]  mtype;
      logic [START_W-1:0] start;
      logic [PAGES_W-1:0] pages;
      n = 0;
      while (n < count) begin
         r = $urandom_range(99);
         start = {$urandom, $urandom};
         if (r < 12) begin
            case ($urandom_range(2))
               0: mtype = MT_BOOT_CODE;
               1: mtype = MT_BOOT_DATA;
               default: mtype = MT_CONVENTIONAL;
            endcase
            pages = pick_pages();
            if ($urandom_range(9) != 0) start[UNIT_SHIFT-1:0] = '0;
            send_request(CMD_ADD, mtype, start, pages, BYTES_W'($urandom));
            usable_sent++;
            n++;
            // ask for the whole new region right away, an exact fit if it was stored
            if (pages != 0 && pages <= 255 && $urandom_range(99) < 30) begin
               send_request(CMD_ALLOC, TYPE_W'($urandom), {$urandom, $urandom},
                            PAGES_W'({$urandom, $urandom}),
                            BYTES_W'((((int'(pages) << PAGE_SHIFT) - 1) << UNIT_SHIFT)
                                     - $urandom_range(15)));
               n++;
            end
         end else if (r < 20) begin
            do mtype = TYPE_W'($urandom);
            while (mtype == MT_BOOT_CODE || mtype == MT_BOOT_DATA || mtype == MT_CONVENTIONAL);
            send_request(CMD_ADD, mtype, start, PAGES_W'({$urandom, $urandom}),
                         BYTES_W'($urandom));
            n++;
         end else begin
            send_request(CMD_ALLOC, TYPE_W'($urandom), start, PAGES_W'({$urandom, $urandom}),
                         pick_bytes());
            n++;
         end
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.command       <= CMD_ADD;
      req_chan.mem_type      <= '0;
      req_chan.region_start  <= '0;
      req_chan.page_count    <= '0;
      req_chan.request_bytes <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(RANDOM_PER_PHASE);
      gap_pct   = 50;
      stall_pct = 12;
      run_random(RANDOM_PER_PHASE);
      gap_pct   = 0;
      stall_pct = 0;
      run_random(RANDOM_PER_PHASE);
      req_chan.valid <= 1'b0;

      @(posedge clock);
      wait (results_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && results_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
